@@ hw/rtl/bsem_pkg.sv @@
// Shared types and codes for the bounded semaphore table.
`default_nettype none

package bsem_pkg;

    // Request codes
    localparam logic [2:0] REQ_OPEN  = 3'd0;
    localparam logic [2:0] REQ_CLOSE = 3'd1;
    localparam logic [2:0] REQ_UP    = 3'd2;
    localparam logic [2:0] REQ_DOWN  = 3'd3;
    localparam logic [2:0] REQ_ALLOC = 3'd4;

    // Status codes
    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_WRONG_STATE = 3'd1;
    localparam logic [2:0] ST_AT_BOUND    = 3'd2;
    localparam logic [2:0] ST_WOULD_BLOCK = 3'd3;
    localparam logic [2:0] ST_FULL        = 3'd4;

    localparam int IDX_FIELD_BITS  = 8;
    localparam int INIT_FIELD_BITS = 16;

    typedef struct packed {
        logic [2:0]                   req_type;
        logic [IDX_FIELD_BITS-1:0]    sem_index;
        logic [INIT_FIELD_BITS-1:0]   init_value;
    } t_bsem_req;

    typedef struct packed {
        logic [2:0]                   status;
        logic [IDX_FIELD_BITS-1:0]    alloc_index;
        logic                         wake;
    } t_bsem_result;

endpackage

`default_nettype wire

@@ hw/rtl/bounded_semaphore_table.sv @@
// Bounded counting semaphore table: top level with request execute stage.
//
// Takes one request per clock (start while busy is low) and returns exactly one
// result for each, marked by o_done for a single cycle; the receiver
// cannot stall, so results must be taken as they appear. The result passes through
// the registered read of the count/bound memory and then the execute register;
// back-to-back requests on the same entry are forwarded, so the rate holds at
// one per cycle. busy is high during reset and in the first cycle after it. Allocate
// picks the lowest closed entry with a priority tree over the open marks.
`default_nettype none

module bounded_semaphore_table
    import bsem_pkg::*;
#(
    parameter int SEM_ENTRIES = 256,
    parameter int COUNT_BITS  = 16
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         start,
    input  wire t_bsem_req    i_req,
    output logic              busy,
    output logic              o_done,
    output t_bsem_result      o_result
);

    localparam int AW = $clog2(SEM_ENTRIES);
    localparam int XW = ((AW > IDX_FIELD_BITS) ? AW : IDX_FIELD_BITS) + 1;
    localparam int VW = (COUNT_BITS > INIT_FIELD_BITS) ? COUNT_BITS : INIT_FIELD_BITS;

    logic                   r_busy;
    logic                   r_valid;
    t_bsem_req              r_req;
    logic [SEM_ENTRIES-1:0] r_marks;
    logic                   r_done;
    t_bsem_result           r_result;

    logic                   accept;
    logic [XW-1:0]          in_ext;
    logic [XW-1:0]          ex_ext;
    logic [AW-1:0]          ex_addr;
    logic                   ex_in_range;
    logic [VW-1:0]          val_ext;
    logic [COUNT_BITS-1:0]  ex_val;
    logic [COUNT_BITS-1:0]  cur_count;
    logic [COUNT_BITS-1:0]  cur_bound;
    logic                   ffz_found;
    logic [AW-1:0]          ffz_index;

    t_bsem_result           n_result;
    logic                   mark_we;
    logic                   mark_val;
    logic [AW-1:0]          wr_addr;
    logic                   wr_count_en;
    logic                   wr_bound_en;
    logic [COUNT_BITS-1:0]  wr_count;

    assign accept = start && !r_busy;
    assign busy   = r_busy;

    assign in_ext      = XW'(i_req.sem_index);
    assign ex_ext      = XW'(r_req.sem_index);
    assign ex_addr     = ex_ext[AW-1:0];
    assign ex_in_range = ex_ext < XW'(SEM_ENTRIES);
    assign val_ext     = VW'(r_req.init_value);
    assign ex_val      = val_ext[COUNT_BITS-1:0];

    bsem_store #(
        .ENTRIES (SEM_ENTRIES),
        .AW      (AW),
        .CB      (COUNT_BITS)
    ) u_store (
        .i_clk         (i_clk),
        .i_rd_addr     (in_ext[AW-1:0]),
        .i_wr_addr     (wr_addr),
        .i_wr_count_en (wr_count_en),
        .i_wr_count    (wr_count),
        .i_wr_bound_en (wr_bound_en),
        .i_wr_bound    (ex_val),
        .o_count       (cur_count),
        .o_bound       (cur_bound)
    );

    bsem_ffz #(
        .ENTRIES (SEM_ENTRIES),
        .AW      (AW)
    ) u_ffz (
        .i_marks (r_marks),
        .o_found (ffz_found),
        .o_index (ffz_index)
    );

    always_comb begin
        n_result    = '{status: ST_OK, alloc_index: '0, wake: 1'b0};
        mark_we     = 1'b0;
        mark_val    = 1'b0;
        wr_addr     = ex_addr;
        wr_count_en = 1'b0;
        wr_bound_en = 1'b0;
        wr_count    = ex_val;
        if (r_valid) begin
            case (r_req.req_type)
                REQ_OPEN: begin
                    if (!ex_in_range || r_marks[ex_addr]) begin
                        n_result.status = ST_WRONG_STATE;
                    end else begin
                        mark_we     = 1'b1;
                        mark_val    = 1'b1;
                        wr_count_en = 1'b1;
                        wr_bound_en = 1'b1;
                    end
                end
                REQ_CLOSE: begin
                    if (!ex_in_range || !r_marks[ex_addr]) begin
                        n_result.status = ST_WRONG_STATE;
                    end else begin
                        mark_we = 1'b1;
                    end
                end
                REQ_UP: begin
                    if (!ex_in_range || !r_marks[ex_addr]) begin
                        n_result.status = ST_WRONG_STATE;
                    end else if (cur_count >= cur_bound) begin
                        n_result.status = ST_AT_BOUND;
                    end else begin
                        wr_count_en   = 1'b1;
                        wr_count      = cur_count + COUNT_BITS'(1);
                        n_result.wake = 1'b1;
                    end
                end
                REQ_DOWN: begin
                    if (!ex_in_range || !r_marks[ex_addr]) begin
                        n_result.status = ST_WRONG_STATE;
                    end else if (cur_count == '0) begin
                        n_result.status = ST_WOULD_BLOCK;
                    end else begin
                        wr_count_en = 1'b1;
                        wr_count    = cur_count - COUNT_BITS'(1);
                    end
                end
                REQ_ALLOC: begin
                    if (ffz_found) begin
                        wr_addr              = ffz_index;
                        mark_we              = 1'b1;
                        mark_val             = 1'b1;
                        wr_count_en          = 1'b1;
                        wr_bound_en          = 1'b1;
                        n_result.alloc_index = IDX_FIELD_BITS'(ffz_index);
                    end else begin
                        n_result.status = ST_FULL;
                    end
                end
                default: begin
                    // unused codes: answer ok, touch nothing
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b1;
            r_valid <= 1'b0;
            r_done  <= 1'b0;
            r_marks <= '0;
        end else begin
            r_busy  <= 1'b0;
            r_valid <= accept;
            r_done  <= r_valid;
            if (mark_we) begin
                r_marks[wr_addr] <= mark_val;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req <= i_req;
        end
        r_result <= n_result;
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

`default_nettype wire

@@ hw/rtl/bsem_ffz.sv @@
// Binary tree that finds the lowest closed entry in the open-mark vector.
`default_nettype none

module bsem_ffz #(
    parameter int ENTRIES = 256,
    parameter int AW      = 8
) (
    input  wire logic [ENTRIES-1:0] i_marks,
    output logic                    o_found,
    output logic [AW-1:0]           o_index
);

    localparam int LVLS = $clog2(ENTRIES);
    localparam int PAD  = 2 ** LVLS;

    logic          found [LVLS+1][PAD];
    logic [AW-1:0] idx   [LVLS+1][PAD];

    genvar l, j;
    generate
        for (j = 0; j < PAD; j++) begin : g_leaf
            if (j < ENTRIES) begin : g_real
                assign found[0][j] = ~i_marks[j];
            end else begin : g_pad
                assign found[0][j] = 1'b0;
            end
            assign idx[0][j] = '0;
        end
        for (l = 0; l < LVLS; l++) begin : g_lvl
            for (j = 0; j < (PAD >> (l + 1)); j++) begin : g_node
                // prefer the left (lower) child; right child sets bit l
                assign found[l+1][j] = found[l][2*j] | found[l][2*j+1];
                assign idx[l+1][j]   = found[l][2*j] ? idx[l][2*j]
                                     : (idx[l][2*j+1] | (AW'(1) << l));
            end
            for (j = (PAD >> (l + 1)); j < PAD; j++) begin : g_unused
                assign found[l+1][j] = 1'b0;
                assign idx[l+1][j]   = '0;
            end
        end
    endgenerate

    assign o_found = found[LVLS][0];
    assign o_index = idx[LVLS][0];

endmodule

`default_nettype wire

@@ hw/rtl/bsem_store.sv @@
// Count and bound memories with registered read and same-edge write bypass.
`default_nettype none

module bsem_store #(
    parameter int ENTRIES = 256,
    parameter int AW      = 8,
    parameter int CB      = 16
) (
    input  wire logic          i_clk,
    input  wire logic [AW-1:0] i_rd_addr,
    input  wire logic [AW-1:0] i_wr_addr,
    input  wire logic          i_wr_count_en,
    input  wire logic [CB-1:0] i_wr_count,
    input  wire logic          i_wr_bound_en,
    input  wire logic [CB-1:0] i_wr_bound,
    output logic      [CB-1:0] o_count,
    output logic      [CB-1:0] o_bound
);

    logic [CB-1:0] r_counts [ENTRIES];
    logic [CB-1:0] r_bounds [ENTRIES];
    logic [CB-1:0] r_rd_count;
    logic [CB-1:0] r_rd_bound;
    logic [CB-1:0] r_fwd_count;
    logic [CB-1:0] r_fwd_bound;
    logic          r_hit_count;
    logic          r_hit_bound;

    always_ff @(posedge i_clk) begin
        if (i_wr_count_en) begin
            r_counts[i_wr_addr] <= i_wr_count;
        end
        if (i_wr_bound_en) begin
            r_bounds[i_wr_addr] <= i_wr_bound;
        end
        r_rd_count  <= r_counts[i_rd_addr];
        r_rd_bound  <= r_bounds[i_rd_addr];
        // catch the write landing on the same entry at this edge
        r_hit_count <= i_wr_count_en && (i_wr_addr == i_rd_addr);
        r_hit_bound <= i_wr_bound_en && (i_wr_addr == i_rd_addr);
        r_fwd_count <= i_wr_count;
        r_fwd_bound <= i_wr_bound;
    end

    assign o_count = r_hit_count ? r_fwd_count : r_rd_count;
    assign o_bound = r_hit_bound ? r_fwd_bound : r_rd_bound;

endmodule

`default_nettype wire

@@ hw/rtl/bsem_checker.sv @@
// Port-level checker for the bounded semaphore table, bound to the top level.
`default_nettype none

module bsem_checker
    import bsem_pkg::*;
(
    input wire logic         i_clk,
    input wire logic         i_rst_n,
    input wire logic         start,
    input wire logic         busy,
    input wire logic         o_done,
    input wire t_bsem_result o_result
);

    // every accepted beat comes back as a result beat
    a_done_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> ##1 o_done)
        else $error("result beat missing after accepted request");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start && !busy, 2))
        else $error("result beat without a request");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_result.status == ST_OK || o_result.status == ST_WRONG_STATE ||
                    o_result.status == ST_AT_BOUND || o_result.status == ST_WOULD_BLOCK ||
                    o_result.status == ST_FULL))
        else $error("undefined status code");

    // wake and a nonzero allocated index only come with success
    a_wake_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_result.wake || o_result.alloc_index != '0)) |->
        (o_result.status == ST_OK))
        else $error("wake or alloc index on a failed request");

endmodule

bind bounded_semaphore_table bsem_checker u_bsem_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_done   (o_done),
    .o_result (o_result)
);

`default_nettype wire

@@ test/tb.sv @@
// Self-checking testbench for the bounded semaphore table.
`timescale 1ns / 100ps

module tb;
    import bsem_pkg::*;

    localparam int ENTRIES     = 256;
    localparam int CYCLE_LIMIT = 200000;

    // Mirror of the semaphore table; predicts one result per accepted request.
    class sem_table_mirror;
        bit           opened[ENTRIES];
        logic [15:0]  level[ENTRIES];
        logic [15:0]  ceiling[ENTRIES];
        t_bsem_result due_results[$];
        int           mismatch_count;

        function new();
            foreach (opened[i]) opened[i] = 1'b0;
            mismatch_count = 0;
        endfunction

        function void apply_request(t_bsem_req r);
            t_bsem_result res;
            int           slot;
            res  = '0;
            slot = -1;
            res.status = ST_OK;
            case (r.req_type)
                REQ_OPEN: begin
                    if (opened[r.sem_index]) begin
                        res.status = ST_WRONG_STATE;
                    end else begin
                        opened[r.sem_index]  = 1'b1;
                        level[r.sem_index]   = r.init_value;
                        ceiling[r.sem_index] = r.init_value;
                    end
                end
                REQ_CLOSE, REQ_UP, REQ_DOWN: begin
                    if (!opened[r.sem_index]) begin
                        res.status = ST_WRONG_STATE;
                    end else if (r.req_type == REQ_CLOSE) begin
                        opened[r.sem_index] = 1'b0;
                    end else if (r.req_type == REQ_UP) begin
                        if (level[r.sem_index] >= ceiling[r.sem_index]) begin
                            res.status = ST_AT_BOUND;
                        end else begin
                            level[r.sem_index] = level[r.sem_index] + 16'd1;
                            res.wake = 1'b1;
                        end
                    end else begin
                        if (level[r.sem_index] == 16'd0) begin
                            res.status = ST_WOULD_BLOCK;
                        end else begin
                            level[r.sem_index] = level[r.sem_index] - 16'd1;
                        end
                    end
                end
                REQ_ALLOC: begin
                    // lowest closed entry wins
                    for (int i = 0; i < ENTRIES; i++) begin
                        if (slot < 0 && !opened[i]) slot = i;
                    end
                    if (slot < 0) begin
                        res.status = ST_FULL;
                    end else begin
                        opened[slot]  = 1'b1;
                        level[slot]   = r.init_value;
                        ceiling[slot] = r.init_value;
                        res.alloc_index = slot[7:0];
                    end
                end
                default: ;
            endcase
            due_results.push_back(res);
        endfunction

        function void match_result(t_bsem_result got);
            t_bsem_result want;
            if (due_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time, got);
                mismatch_count++;
                return;
            end
            want = due_results.pop_front();
            if (got.status !== want.status) begin
                $display("%0t: status mismatch, expected %0d, actual %0d",
                         $time, want.status, got.status);
                mismatch_count++;
            end
            if (got.alloc_index !== want.alloc_index) begin
                $display("%0t: alloc_index mismatch, expected %0d, actual %0d",
                         $time, want.alloc_index, got.alloc_index);
                mismatch_count++;
            end
            if (got.wake !== want.wake) begin
                $display("%0t: wake mismatch, expected %b, actual %b",
                         $time, want.wake, got.wake);
                mismatch_count++;
            end
        endfunction
    endclass

    logic         i_clk;
    logic         i_rst_n = 1'b0;
    logic         start   = 1'b0;
    t_bsem_req    i_req   = '0;
    logic         busy;
    logic         o_done;
    t_bsem_result o_result;

    sem_table_mirror mirror;
    int              cycles   = 0;
    bit              idle_on  = 1'b1;
    int              win_base = 0;

    bounded_semaphore_table dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_req    (i_req),
        .busy     (busy),
        .o_done   (o_done),
        .o_result (o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Note each accepted beat and check each result strobe.
    always @(posedge i_clk) begin
        if (i_rst_n && start && !busy) mirror.apply_request(i_req);
        if (i_rst_n && o_done) mirror.match_result(o_result);
    end

    function automatic t_bsem_req mk_req(logic [2:0] op, logic [7:0] idx, logic [15:0] val);
        t_bsem_req r;
        r.req_type   = op;
        r.sem_index  = idx;
        r.init_value = val;
        return r;
    endfunction

    function automatic logic [15:0] pick_init();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 60) return 16'($urandom_range(3));
        if (roll < 80) return 16'($urandom);
        if (roll < 90) return 16'd0;
        return 16'hFFFF;
    endfunction

    function automatic logic [7:0] pick_index(bit wide);
        if (wide) return 8'($urandom_range(255));
        return 8'(win_base + $urandom_range(7));
    endfunction

    function automatic t_bsem_req pick_mixed(bit wide);
        int unsigned roll;
        logic [2:0]  op;
        roll = $urandom_range(99);
        if (roll < 20)      op = REQ_OPEN;
        else if (roll < 30) op = REQ_CLOSE;
        else if (roll < 55) op = REQ_UP;
        else if (roll < 80) op = REQ_DOWN;
        else if (roll < 92) op = REQ_ALLOC;
        else                op = 3'($urandom_range(5, 7));
        return mk_req(op, pick_index(wide), pick_init());
    endfunction

    task automatic drive_beat(t_bsem_req r);
        int gap;
        gap = 0;
        if (idle_on && $urandom_range(99) < 20) gap = $urandom_range(1, 3);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_req <= r;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    initial begin
        mirror = new();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed corners
        drive_beat(mk_req(REQ_OPEN,  8'd0,   16'd0));
        drive_beat(mk_req(REQ_UP,    8'd0,   16'd0));
        drive_beat(mk_req(REQ_DOWN,  8'd0,   16'd0));
        drive_beat(mk_req(REQ_OPEN,  8'd0,   16'd5));
        drive_beat(mk_req(REQ_CLOSE, 8'd0,   16'd0));
        drive_beat(mk_req(REQ_CLOSE, 8'd0,   16'd0));
        drive_beat(mk_req(REQ_UP,    8'd0,   16'd0));
        drive_beat(mk_req(REQ_DOWN,  8'd0,   16'd0));
        drive_beat(mk_req(REQ_OPEN,  8'd255, 16'hFFFF));
        drive_beat(mk_req(REQ_DOWN,  8'd255, 16'd0));
        drive_beat(mk_req(REQ_UP,    8'd255, 16'd0));
        drive_beat(mk_req(REQ_UP,    8'd255, 16'd0));
        drive_beat(mk_req(REQ_ALLOC, 8'd0,   16'h1234));
        drive_beat(mk_req(REQ_ALLOC, 8'hFF,  16'hFFFF));
        drive_beat(mk_req(REQ_OPEN,  8'd2,   16'd1));
        drive_beat(mk_req(REQ_DOWN,  8'd2,   16'd0));
        drive_beat(mk_req(REQ_DOWN,  8'd2,   16'd0));
        drive_beat(mk_req(REQ_UP,    8'd2,   16'd0));
        drive_beat(mk_req(3'd5,      8'hAA,  16'h5555));
        drive_beat(mk_req(3'd6,      8'h55,  16'hAAAA));
        drive_beat(mk_req(3'd7,      8'hFF,  16'hFFFF));
        drive_beat(mk_req(REQ_CLOSE, 8'd255, 16'd0));
        drive_beat(mk_req(REQ_CLOSE, 8'd0,   16'd0));
        drive_beat(mk_req(REQ_CLOSE, 8'd1,   16'd0));
        drive_beat(mk_req(REQ_CLOSE, 8'd2,   16'd0));

        // random traffic on a small window so entries see full open/up/down/close lives
        for (int n = 0; n < 150; n++) begin
            idle_on = !(n >= 40 && n < 110);
            drive_beat(pick_mixed($urandom_range(99) < 10));
        end

        // fill the table, then keep allocating against a full table
        for (int n = 0; n < ENTRIES + 4; n++) drive_beat(mk_req(REQ_ALLOC, 8'($urandom), pick_init()));
        for (int n = 0; n < 4; n++) begin
            drive_beat(mk_req(REQ_CLOSE, 8'($urandom), 16'($urandom)));
            drive_beat(mk_req(REQ_ALLOC, 8'($urandom), pick_init()));
            drive_beat(mk_req(REQ_ALLOC, 8'($urandom), pick_init()));
        end
        for (int n = 0; n < 64; n++) drive_beat(mk_req(REQ_CLOSE, 8'(n * 4), 16'($urandom)));

        // random traffic over moving windows across the whole index range
        for (int n = 0; n < 150; n++) begin
            if (n % 50 == 0) win_base = $urandom_range(248);
            drive_beat(pick_mixed($urandom_range(99) < 30));
        end

        start <= 1'b0;
        while (mirror.due_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (mirror.mismatch_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
